FILE: hdl/ptd_pkg.sv
package ptd_pkg;

   typedef enum logic [2:0] {
      CMD_CLEAR    = 3'd0,
      CMD_REGISTER = 3'd1,
      CMD_ENABLE   = 3'd2,
      CMD_DISABLE  = 3'd3,
      CMD_TICK     = 3'd4,
      CMD_RUN      = 3'd5
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REG_MUL,
      ST_REG_WR,
      ST_EN_RD,
      ST_EN_WR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_SCAN_FIX,
      ST_SCAN_END
   } state_type;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam int PERIOD_W   = 16;
   localparam int INTERVAL_W = 13;
   localparam int TICK_W     = 32;
   localparam int INDEX_W    = 6;
   localparam int ID_W       = 8;

   // ms to ticks: period / 10 as (period * 52429) >> 19, exact for 16-bit periods
   localparam logic [PERIOD_W-1:0] DIV10_MUL   = 16'd52429;
   localparam int                  DIV10_SHIFT = 19;

   localparam int RESULT_CAP = 16;
   localparam int FOUND_W    = $clog2(RESULT_CAP + 1);

endpackage

FILE: hdl/periodic_task_dispatcher_top.sv
// Periodic task dispatcher. A command is taken when start is high and busy is low; busy
// stays high until the command's last result has been issued. Results come as one-cycle
// strobes on rsp_valid, at most one per cycle, and cannot be held off, so the receiver must
// take every beat. Clear, tick, disable, unknown codes, a run on an empty table, enable of
// an enabled slot and every rejection answer in the cycle after acceptance; register passes
// through a divide-by-ten multiply state and then a slot write state, and enabling a
// disabled slot through a slot memory read state and then a write state.
// A run command has a slot read and a check state per slot, a fix-up state for each due
// periodic slot and an end state at the close: each slot needs one read of the slot memory
// and one or two passes through the single shared 32-bit adder and compare. A run emits one
// beat per due slot in slot order (at most 16), or one beat with due_valid low if none is due.
module periodic_task_dispatcher_top #(
   parameter int SLOT_COUNT = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_cmd,
   input  logic [15:0] req_period_ms,
   input  logic [ptd_pkg::ID_W-1:0] req_slot_id,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_task_index,
   output logic       rsp_due_valid,
   output logic       rsp_last
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   ptd_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]                    total_ff, total_in;
   logic [ptd_pkg::TICK_W-1:0]          tick_ff, tick_in;
   logic [SLOT_COUNT-1:0]               enabled_ff, enabled_in;
   logic [IDX_W-1:0]                    id_ff, id_in;
   logic [ptd_pkg::PERIOD_W-1:0]        period_ff, period_in;
   logic [31:0]                         prod_ff, prod_in;
   logic [CNT_W-1:0]                    idx_ff, idx_in;
   logic [ptd_pkg::FOUND_W-1:0]         found_ff, found_in;
   logic [IDX_W-1:0]                    pend_ff, pend_in;
   logic                                pend_valid_ff, pend_valid_in;
   logic [ptd_pkg::TICK_W-1:0]          sum_ff, sum_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [1:0]                          rsp_status_ff, rsp_status_in;
   logic [ptd_pkg::INDEX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic                                rsp_due_ff, rsp_due_in;
   logic                                rsp_last_ff, rsp_last_in;

   // slot memory
   logic [ptd_pkg::INTERVAL_W-1:0]      interval_mem [SLOT_COUNT];
   logic [ptd_pkg::TICK_W-1:0]          next_due_mem [SLOT_COUNT];
   logic [ptd_pkg::INTERVAL_W-1:0]      rd_interval_ff;
   logic [ptd_pkg::TICK_W-1:0]          rd_next_due_ff;
   logic                                rd_en;
   logic [IDX_W-1:0]                    rd_addr;
   logic                                int_we;
   logic                                due_we;
   logic [IDX_W-1:0]                    wr_addr;
   logic [ptd_pkg::INTERVAL_W-1:0]      wr_interval;
   logic [ptd_pkg::TICK_W-1:0]          wr_next_due;

   // shared adder and compare
   logic [ptd_pkg::TICK_W-1:0]          add_a;
   logic [ptd_pkg::INTERVAL_W-1:0]      add_b;
   logic [ptd_pkg::TICK_W-1:0]          add_sum;
   logic [ptd_pkg::TICK_W-1:0]          cmp_b;
   logic                                tick_ge;

   logic                                accept;
   logic                                id_in_range;
   logic [IDX_W-1:0]                    req_idx;
   logic [ptd_pkg::INTERVAL_W-1:0]      quot;
   logic [ptd_pkg::INTERVAL_W-1:0]      ticks;
   logic [IDX_W-1:0]                    cur_idx;
   logic [CNT_W-1:0]                    idx_inc;
   logic                                slot_done;
   logic                                due_here;
   logic [ptd_pkg::FOUND_W-1:0]         found_next;

   assign accept      = start && (state_ff == ptd_pkg::ST_IDLE);
   assign id_in_range = {1'b0, req_slot_id} < 9'(total_ff);
   assign req_idx     = req_slot_id[IDX_W-1:0];
   assign cur_idx     = idx_ff[IDX_W-1:0];
   assign idx_inc     = idx_ff + CNT_W'(1);
   assign found_next  = found_ff + ptd_pkg::FOUND_W'(due_here);

   assign quot  = prod_ff[ptd_pkg::DIV10_SHIFT +: ptd_pkg::INTERVAL_W];
   assign ticks = (quot == '0 && period_ff != '0) ? ptd_pkg::INTERVAL_W'(1) : quot;

   always_comb begin
      add_a = tick_ff;
      add_b = ptd_pkg::INTERVAL_W'(1);
      cmp_b = sum_ff;
      case (state_ff)
         ptd_pkg::ST_REG_WR: begin
            add_b = ticks;
         end
         ptd_pkg::ST_EN_WR, ptd_pkg::ST_SCAN_FIX: begin
            add_b = rd_interval_ff;
         end
         ptd_pkg::ST_SCAN_CHK: begin
            add_a = rd_next_due_ff;
            add_b = rd_interval_ff;
            cmp_b = rd_next_due_ff;
         end
         default: begin
         end
      endcase
   end

   assign add_sum = add_a + ptd_pkg::TICK_W'(add_b);
   assign tick_ge = tick_ff >= cmp_b;

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      tick_in       = tick_ff;
      enabled_in    = enabled_ff;
      id_in         = id_ff;
      period_in     = period_ff;
      prod_in       = prod_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ptd_pkg::STATUS_DONE;
      rsp_index_in  = '0;
      rsp_due_in    = 1'b0;
      rsp_last_in   = 1'b1;
      rd_en         = 1'b0;
      rd_addr       = cur_idx;
      int_we        = 1'b0;
      due_we        = 1'b0;
      wr_addr       = cur_idx;
      wr_interval   = ticks;
      wr_next_due   = add_sum;
      slot_done     = 1'b0;
      due_here      = 1'b0;

      case (state_ff)
         ptd_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               case (req_cmd)
                  ptd_pkg::CMD_CLEAR: begin
                     total_in   = '0;
                     enabled_in = '0;
                  end
                  ptd_pkg::CMD_REGISTER: begin
                     if (total_ff == CNT_W'(SLOT_COUNT)) begin
                        rsp_status_in = ptd_pkg::STATUS_FULL;
                     end else begin
                        rsp_valid_in = 1'b0;
                        period_in    = req_period_ms;
                        state_in     = ptd_pkg::ST_REG_MUL;
                     end
                  end
                  ptd_pkg::CMD_ENABLE: begin
                     if (!id_in_range) begin
                        rsp_status_in = ptd_pkg::STATUS_RANGE;
                     end else if (!enabled_ff[req_idx]) begin
                        rsp_valid_in = 1'b0;
                        id_in        = req_idx;
                        state_in     = ptd_pkg::ST_EN_RD;
                     end
                  end
                  ptd_pkg::CMD_DISABLE: begin
                     if (!id_in_range) begin
                        rsp_status_in = ptd_pkg::STATUS_RANGE;
                     end else begin
                        enabled_in[req_idx] = 1'b0;
                     end
                  end
                  ptd_pkg::CMD_TICK: begin
                     tick_in = add_sum;
                  end
                  ptd_pkg::CMD_RUN: begin
                     if (total_ff != '0) begin
                        rsp_valid_in  = 1'b0;
                        idx_in        = '0;
                        found_in      = '0;
                        pend_valid_in = 1'b0;
                        state_in      = ptd_pkg::ST_SCAN_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ptd_pkg::ST_REG_MUL: begin
            prod_in  = 32'(period_ff) * 32'(ptd_pkg::DIV10_MUL);
            state_in = ptd_pkg::ST_REG_WR;
         end
         ptd_pkg::ST_REG_WR: begin
            int_we               = 1'b1;
            due_we               = 1'b1;
            wr_addr              = total_ff[IDX_W-1:0];
            enabled_in[wr_addr]  = 1'b0;
            total_in             = total_ff + CNT_W'(1);
            rsp_valid_in         = 1'b1;
            rsp_index_in         = ptd_pkg::INDEX_W'(total_ff);
            state_in             = ptd_pkg::ST_IDLE;
         end
         ptd_pkg::ST_EN_RD: begin
            rd_en    = 1'b1;
            rd_addr  = id_ff;
            state_in = ptd_pkg::ST_EN_WR;
         end
         ptd_pkg::ST_EN_WR: begin
            due_we            = 1'b1;
            wr_addr           = id_ff;
            enabled_in[id_ff] = 1'b1;
            rsp_valid_in      = 1'b1;
            state_in          = ptd_pkg::ST_IDLE;
         end
         ptd_pkg::ST_SCAN_RD: begin
            rd_en    = 1'b1;
            state_in = ptd_pkg::ST_SCAN_CHK;
         end
         ptd_pkg::ST_SCAN_CHK: begin
            if (!(enabled_ff[cur_idx] && tick_ge)) begin
               slot_done = 1'b1;
            end else if (rd_interval_ff == '0) begin
               // one-shot: drop it after this beat
               enabled_in[cur_idx] = 1'b0;
               slot_done           = 1'b1;
               due_here            = 1'b1;
            end else begin
               sum_in   = add_sum;
               state_in = ptd_pkg::ST_SCAN_FIX;
            end
         end
         ptd_pkg::ST_SCAN_FIX: begin
            // still behind after one interval: restart from now
            due_we      = 1'b1;
            wr_next_due = tick_ge ? add_sum : sum_ff;
            slot_done   = 1'b1;
            due_here    = 1'b1;
         end
         ptd_pkg::ST_SCAN_END: begin
            rsp_valid_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_index_in = ptd_pkg::INDEX_W'(pend_ff);
               rsp_due_in   = 1'b1;
            end
            state_in = ptd_pkg::ST_IDLE;
         end
         default: begin
            state_in = ptd_pkg::ST_IDLE;
         end
      endcase

      if (slot_done) begin
         // hold the newest due slot so the final beat can carry last
         if (due_here) begin
            pend_in       = cur_idx;
            pend_valid_in = 1'b1;
            found_in      = found_next;
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = ptd_pkg::INDEX_W'(pend_ff);
               rsp_due_in   = 1'b1;
               rsp_last_in  = 1'b0;
            end
         end
         if (idx_inc >= total_ff || found_next == ptd_pkg::FOUND_W'(ptd_pkg::RESULT_CAP)) begin
            state_in = ptd_pkg::ST_SCAN_END;
         end else begin
            idx_in   = idx_inc;
            state_in = ptd_pkg::ST_SCAN_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptd_pkg::ST_IDLE;
         total_ff      <= '0;
         tick_ff       <= '0;
         enabled_ff    <= '0;
         pend_valid_ff <= 1'b0;
         found_ff      <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         tick_ff       <= tick_in;
         enabled_ff    <= enabled_in;
         pend_valid_ff <= pend_valid_in;
         found_ff      <= found_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      period_ff     <= period_in;
      prod_ff       <= prod_in;
      pend_ff       <= pend_in;
      sum_ff        <= sum_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_due_ff    <= rsp_due_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (int_we) begin
         interval_mem[wr_addr] <= wr_interval;
      end
      if (due_we) begin
         next_due_mem[wr_addr] <= wr_next_due;
      end
      if (rd_en) begin
         rd_interval_ff <= interval_mem[rd_addr];
         rd_next_due_ff <= next_due_mem[rd_addr];
      end
   end

   assign busy           = (state_ff != ptd_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_task_index = rsp_index_ff;
   assign rsp_due_valid  = rsp_due_ff;
   assign rsp_last       = rsp_last_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(SLOT_COUNT))
      else $error("slot count above table size");

   a_idle_beat_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_due_valid |-> rsp_last)
      else $error("non-due beat without last");

   a_quick_cmd: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_cmd == ptd_pkg::CMD_CLEAR || req_cmd == ptd_pkg::CMD_TICK)
      |=> rsp_valid && rsp_last && !busy)
      else $error("single-cycle command gave no final beat");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cmd == ptd_pkg::CMD_TICK
      |=> tick_ff == $past(tick_ff) + 32'd1)
      else $error("tick did not advance by one");

   a_found_cap: assert property (@(posedge clock) disable iff (reset)
      found_ff <= ptd_pkg::FOUND_W'(ptd_pkg::RESULT_CAP))
      else $error("scan emitted more than the beat cap");

endmodule
